@@ sv/adam_pkg.sv @@
package adam_pkg;

  // float32 constants
  localparam logic [31:0] BETA1    = 32'h3CCC_CCCD;  // 0.025
  localparam logic [31:0] BETA2    = 32'h3F7F_F972;  // 0.9999
  localparam logic [31:0] C1       = 32'h3F79_999A;  // 1 - 0.025
  localparam logic [31:0] C2       = 32'h38D1_C000;  // 1 - 0.9999
  localparam logic [31:0] DEF_NAN  = 32'hFFC0_0000;
  localparam logic [31:0] SQRT_NAN = 32'h7FC0_0000;
  localparam logic [31:0] QBIT     = 32'h0040_0000;

  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 26;
  localparam int LAT        = 73;

  typedef enum logic {
    REG_STEP_SCALE = 1'b0,
    REG_EPS_TERM   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] gradient;
    logic [31:0] first_moment;
    logic [31:0] second_moment;
    logic [31:0] weight;
    logic        last_element;
  } in_t;

  typedef struct packed {
    logic [31:0] new_first_moment;
    logic [31:0] new_second_moment;
    logic [31:0] new_weight;
    logic        last_out;
  } res_t;

  // value ready for rounding: leading one at bit 26, low two bits sticky
  typedef struct packed {
    logic               spec;
    logic [31:0]        sval;
    logic               sign;
    logic signed [10:0] be;
    logic [26:0]        sig;
  } rnd_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        sval;
    logic               sign;
    logic signed [10:0] ex;
    logic [47:0]        prod;
  } mul1_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        sval;
    logic               sign;
    logic               sub;
    logic signed [10:0] ex;
    logic [26:0]        am;
    logic [26:0]        bm;
  } add1_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        sval;
    logic               sign;
    logic signed [10:0] ex;
    logic [27:0]        sum;
  } add2_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        sval;
    logic signed [10:0] be;
    logic [47:0]        n;
    logic [23:0]        root;
    logic [25:0]        rem;
  } sq_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        sval;
    logic               sign;
    logic signed [10:0] be;
    logic [23:0]        dm;
    logic [24:0]        rem;
    logic [25:0]        q;
  } dv_t;

  function automatic logic is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic [31:0] fneg_num(logic [31:0] x);
    return is_nan(x) ? x : {~x[31], x[30:0]};
  endfunction

  function automatic logic [4:0] lzc24(logic [23:0] x);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) if (x[i]) n = 5'(23 - i);
    return n;
  endfunction

  function automatic logic [4:0] lzc27(logic [26:0] x);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) if (x[i]) n = 5'(26 - i);
    return n;
  endfunction

  function automatic logic [5:0] lzc48(logic [47:0] x);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) if (x[i]) n = 6'(47 - i);
    return n;
  endfunction

  function automatic logic [31:0] fp_round(rnd_t r);
    logic [10:0] amt11;
    logic [4:0]  amt;
    logic [26:0] s;
    logic [7:0]  e;
    logic        rnd;
    logic [30:0] mag;
    if (r.spec) return r.sval;
    if (r.sig == 27'd0) return {r.sign, 31'd0};
    if (r.be >= 11'sd255) return {r.sign, 8'hFF, 23'd0};
    if (r.be <= 11'sd0) begin
      amt11 = 11'd1 - r.be;
      amt   = (amt11 > 11'd27) ? 5'd27 : amt11[4:0];
      s     = (r.sig >> amt) | {26'd0, |(r.sig & ~(27'h7FF_FFFF << amt))};
      e     = 8'd0;
    end else begin
      s = r.sig;
      e = r.be[7:0];
    end
    rnd = s[2] & (s[1] | s[0] | s[3]);
    mag = {e, s[25:3]} + 31'(rnd);
    return {r.sign, mag};
  endfunction

  function automatic mul1_t fmul_s1(logic [31:0] a, logic [31:0] b);
    mul1_t      r;
    logic [7:0] ea, eb;
    logic [23:0] ma, mb;
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    r.sign = a[31] ^ b[31];
    r.ex   = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
    r.prod = ma * mb;
    r.spec = 1'b1;
    if (is_nan(a)) r.sval = a | QBIT;
    else if (is_nan(b)) r.sval = b | QBIT;
    else if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
      r.sval = DEF_NAN;
    else if (is_inf(a) || is_inf(b)) r.sval = {r.sign, 8'hFF, 23'd0};
    else begin
      r.spec = 1'b0;
      r.sval = 32'd0;
    end
    return r;
  endfunction

  function automatic rnd_t fmul_s2(mul1_t m);
    rnd_t        r;
    logic [5:0]  lz;
    logic [47:0] ps;
    lz     = lzc48(m.prod);
    ps     = m.prod << lz;
    r.spec = m.spec;
    r.sval = m.sval;
    r.sign = m.sign;
    r.sig  = {ps[47:22], |ps[21:0]};
    r.be   = m.ex - $signed({5'd0, lz});
    return r;
  endfunction

  function automatic add1_t fadd_s1(logic [31:0] a, logic [31:0] b);
    add1_t       r;
    logic [31:0] x, y;
    logic [7:0]  ex8, ey8, d;
    logic [26:0] y0;
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex8    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey8    = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d      = ex8 - ey8;
    r.sign = x[31];
    r.sub  = x[31] ^ y[31];
    r.ex   = $signed({3'b000, ex8});
    r.am   = {x[30:23] != 8'd0, x[22:0], 3'b000};
    y0     = {y[30:23] != 8'd0, y[22:0], 3'b000};
    r.bm   = (y0 >> d) | {26'd0, |(y0 & ~(27'h7FF_FFFF << d))};
    r.spec = 1'b1;
    if (is_nan(a)) r.sval = a | QBIT;
    else if (is_nan(b)) r.sval = b | QBIT;
    else if (is_inf(a) && is_inf(b) && (a[31] != b[31])) r.sval = DEF_NAN;
    else if (is_inf(a)) r.sval = a;
    else if (is_inf(b)) r.sval = b;
    else begin
      r.spec = 1'b0;
      r.sval = 32'd0;
    end
    return r;
  endfunction

  function automatic add2_t fadd_s2(add1_t a);
    add2_t r;
    r.spec = a.spec;
    r.sval = a.sval;
    r.ex   = a.ex;
    r.sum  = a.sub ? ({1'b0, a.am} - {1'b0, a.bm}) : ({1'b0, a.am} + {1'b0, a.bm});
    // exact cancellation gives +0
    r.sign = (a.sub && r.sum == 28'd0) ? 1'b0 : a.sign;
    return r;
  endfunction

  function automatic rnd_t fadd_s3(add2_t a);
    rnd_t       r;
    logic [4:0] lz;
    r.spec = a.spec;
    r.sval = a.sval;
    r.sign = a.sign;
    if (a.sum[27]) begin
      r.sig = {a.sum[27:2], a.sum[1] | a.sum[0]};
      r.be  = a.ex + 11'sd1;
    end else begin
      lz    = lzc27(a.sum[26:0]);
      r.sig = a.sum[26:0] << lz;
      r.be  = a.ex - $signed({6'd0, lz});
    end
    return r;
  endfunction

  function automatic sq_t sqrt_s0(logic [31:0] x);
    sq_t                r;
    logic [4:0]         lz;
    logic [23:0]        m;
    logic signed [10:0] e, q, s11;
    logic [5:0]         s;
    lz = lzc24({1'b0, x[22:0]});
    if (x[30:23] == 8'd0) begin
      m = {1'b0, x[22:0]} << lz;
      e = -11'sd149 - $signed({6'd0, lz});
    end else begin
      m = {1'b1, x[22:0]};
      e = $signed({3'b000, x[30:23]}) - 11'sd150;
    end
    s      = e[0] ? 6'd23 : 6'd24;
    s11    = $signed({5'd0, s});
    q      = (e - s11) >>> 1;
    r.be   = q + 11'sd150;
    r.n    = {24'd0, m} << s;
    r.root = 24'd0;
    r.rem  = 26'd0;
    r.spec = 1'b1;
    if (is_nan(x)) r.sval = x | QBIT;
    else if (x[30:0] == 31'd0) r.sval = x;
    else if (x[31]) r.sval = SQRT_NAN;
    else if (x[30:23] == 8'hFF) r.sval = x;
    else begin
      r.spec = 1'b0;
      r.sval = 32'd0;
    end
    return r;
  endfunction

  function automatic sq_t sqrt_step(sq_t st);
    sq_t         r;
    logic [27:0] rem2, trial;
    rem2 = {st.rem, st.n[47:46]};
    trial = {2'b00, st.root, 2'b01};
    r = st;
    r.n = st.n << 2;
    if (rem2 >= trial) begin
      r.rem  = 26'(rem2 - trial);
      r.root = {st.root[22:0], 1'b1};
    end else begin
      r.rem  = rem2[25:0];
      r.root = {st.root[22:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] sqrt_fin(sq_t st);
    logic [24:0]        rr;
    logic signed [10:0] be;
    if (st.spec) return st.sval;
    rr = {1'b0, st.root} + 25'(st.rem > {2'b00, st.root});
    be = st.be;
    if (rr[24]) begin
      rr = rr >> 1;
      be = be + 11'sd1;
    end
    return {1'b0, be[7:0], rr[22:0]};
  endfunction

  function automatic dv_t div_s0(logic [31:0] a, logic [31:0] b);
    dv_t                r;
    logic [23:0]        ma, mb;
    logic [4:0]         lza, lzb;
    logic signed [10:0] ea, eb;
    ma   = {a[30:23] != 8'd0, a[22:0]};
    mb   = {b[30:23] != 8'd0, b[22:0]};
    lza  = lzc24(ma);
    lzb  = lzc24(mb);
    ea   = $signed({3'b000, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]}) - $signed({6'd0, lza});
    eb   = $signed({3'b000, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}) - $signed({6'd0, lzb});
    r.sign = a[31] ^ b[31];
    r.be   = ea - eb + 11'sd127;
    r.rem  = {1'b0, ma << lza};
    r.dm   = mb << lzb;
    r.q    = 26'd0;
    r.spec = 1'b1;
    if (is_nan(a)) r.sval = a | QBIT;
    else if (is_nan(b)) r.sval = b | QBIT;
    else if ((is_inf(a) && is_inf(b)) || (a[30:0] == 31'd0 && b[30:0] == 31'd0))
      r.sval = DEF_NAN;
    else if (is_inf(a) || b[30:0] == 31'd0) r.sval = {r.sign, 8'hFF, 23'd0};
    else if (is_inf(b) || a[30:0] == 31'd0) r.sval = {r.sign, 31'd0};
    else begin
      r.spec = 1'b0;
      r.sval = 32'd0;
    end
    return r;
  endfunction

  function automatic dv_t div_step(dv_t st);
    dv_t         r;
    logic [24:0] t;
    logic        qb;
    r = st;
    if (st.rem >= {1'b0, st.dm}) begin
      t  = st.rem - {1'b0, st.dm};
      qb = 1'b1;
    end else begin
      t  = st.rem;
      qb = 1'b0;
    end
    r.rem = t << 1;
    r.q   = {st.q[24:0], qb};
    return r;
  endfunction

  function automatic rnd_t div_fin(dv_t st);
    rnd_t r;
    logic sticky;
    sticky = (st.rem != 25'd0);
    r.spec = st.spec;
    r.sval = st.sval;
    r.sign = st.sign;
    if (st.q[25]) begin
      r.sig = {st.q[25:0], sticky};
      r.be  = st.be;
    end else begin
      r.sig = {st.q[24:0], 1'b0, sticky};
      r.be  = st.be - 11'sd1;
    end
    return r;
  endfunction

endpackage

@@ sv/adam_in_if.sv @@
interface adam_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] gradient;
  logic [31:0] first_moment;
  logic [31:0] second_moment;
  logic [31:0] weight;
  logic        last_element;

  modport source (output valid, gradient, first_moment, second_moment, weight,
                  last_element, input ready);
  modport sink (input valid, gradient, first_moment, second_moment, weight,
                last_element, output ready);
endinterface

@@ sv/adam_out_if.sv @@
interface adam_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_first_moment;
  logic [31:0] new_second_moment;
  logic [31:0] new_weight;
  logic        last_out;

  modport source (output valid, new_first_moment, new_second_moment, new_weight,
                  last_out, input ready);
  modport sink (input valid, new_first_moment, new_second_moment, new_weight,
                last_out, output ready);
endinterface

@@ sv/adam_cfg_if.sv @@
interface adam_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/adam_dp.sv @@
module adam_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  adam_pkg::in_t din,
  input  logic [31:0]   scale,
  input  logic [31:0]   eps,
  output logic          out_valid,
  output adam_pkg::res_t dout
);
  import adam_pkg::*;

  logic        v_r [1:LAT];

  mul1_t       ma1_r [4];
  rnd_t        ma2_r [4];
  logic [31:0] ma3_r [4];
  logic [31:0] g_r [1:3];
  logic [31:0] u1_r [4:6];

  mul1_t       mb1_r;
  rnd_t        mb2_r;
  logic [31:0] u3_r;

  add1_t       an1_r, av1_r, ad1_r, as1_r;
  add2_t       an2_r, av2_r, ad2_r, as2_r;
  rnd_t        an3_r, av3_r, ad3_r, as3_r;
  logic [31:0] nm_r, nv_r, den_r, nw_r;

  mul1_t       mn1_r;
  rnd_t        mn2_r;
  logic [31:0] num_r;
  logic [31:0] num_d_r [11:40];

  sq_t         sq_r [0:SQRT_STEPS];
  logic [31:0] root_r;
  dv_t         dv_r [0:DIV_STEPS];
  rnd_t        qr_r;
  logic [31:0] quo_r;

  logic [31:0] w_d_r [1:69];
  logic [31:0] nm_d_r [8:LAT];
  logic [31:0] nv_d_r [11:LAT];
  logic        last_d_r [1:LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= LAT; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[1] <= in_valid;
      for (int i = 2; i <= LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // moment products
      ma1_r[0] <= fmul_s1(din.first_moment, BETA1);
      ma1_r[1] <= fmul_s1(C1, din.gradient);
      ma1_r[2] <= fmul_s1(din.second_moment, BETA2);
      ma1_r[3] <= fmul_s1(C2, din.gradient);
      for (int i = 0; i < 4; i++) begin
        ma2_r[i] <= fmul_s2(ma1_r[i]);
        ma3_r[i] <= fp_round(ma2_r[i]);
      end
      g_r[1] <= din.gradient;
      g_r[2] <= g_r[1];
      g_r[3] <= g_r[2];
      u1_r[4] <= ma3_r[2];
      u1_r[5] <= u1_r[4];
      u1_r[6] <= u1_r[5];

      mb1_r <= fmul_s1(ma3_r[3], g_r[3]);
      mb2_r <= fmul_s2(mb1_r);
      u3_r  <= fp_round(mb2_r);

      // new first moment
      an1_r <= fadd_s1(ma3_r[0], ma3_r[1]);
      an2_r <= fadd_s2(an1_r);
      an3_r <= fadd_s3(an2_r);
      nm_r  <= fp_round(an3_r);

      // new second moment
      av1_r <= fadd_s1(u1_r[6], u3_r);
      av2_r <= fadd_s2(av1_r);
      av3_r <= fadd_s3(av2_r);
      nv_r  <= fp_round(av3_r);

      // denominator before the root
      ad1_r <= fadd_s1(nv_r, eps);
      ad2_r <= fadd_s2(ad1_r);
      ad3_r <= fadd_s3(ad2_r);
      den_r <= fp_round(ad3_r);

      // numerator
      mn1_r <= fmul_s1(scale, nm_r);
      mn2_r <= fmul_s2(mn1_r);
      num_r <= fp_round(mn2_r);
      num_d_r[11] <= num_r;
      for (int i = 12; i <= 40; i++) num_d_r[i] <= num_d_r[i-1];

      // square root, one result bit per stage
      sq_r[0] <= sqrt_s0(den_r);
      for (int i = 1; i <= SQRT_STEPS; i++) sq_r[i] <= sqrt_step(sq_r[i-1]);
      root_r <= sqrt_fin(sq_r[SQRT_STEPS]);

      // divider, one quotient bit per stage
      dv_r[0] <= div_s0(num_d_r[40], root_r);
      for (int i = 1; i <= DIV_STEPS; i++) dv_r[i] <= div_step(dv_r[i-1]);
      qr_r  <= div_fin(dv_r[DIV_STEPS]);
      quo_r <= fp_round(qr_r);

      // weight update
      as1_r <= fadd_s1(w_d_r[69], fneg_num(quo_r));
      as2_r <= fadd_s2(as1_r);
      as3_r <= fadd_s3(as2_r);
      nw_r  <= fp_round(as3_r);

      w_d_r[1] <= din.weight;
      for (int i = 2; i <= 69; i++) w_d_r[i] <= w_d_r[i-1];
      nm_d_r[8] <= nm_r;
      for (int i = 9; i <= LAT; i++) nm_d_r[i] <= nm_d_r[i-1];
      nv_d_r[11] <= nv_r;
      for (int i = 12; i <= LAT; i++) nv_d_r[i] <= nv_d_r[i-1];
      last_d_r[1] <= din.last_element;
      for (int i = 2; i <= LAT; i++) last_d_r[i] <= last_d_r[i-1];
    end
  end

  assign out_valid              = v_r[LAT];
  assign dout.new_first_moment  = nm_d_r[LAT];
  assign dout.new_second_moment = nv_d_r[LAT];
  assign dout.new_weight        = nw_r;
  assign dout.last_out          = last_d_r[LAT];

endmodule

@@ sv/adam_optimizer_update_unit.sv @@
// adam optimizer update, one float32 element per transfer
// in_ch: gradient, first moment, second moment and weight of one element,
//   plus a last-element marker that rides along unchanged
// out_ch: updated first moment, second moment and weight, plus the marker
// cfg_ch: index 0 writes the step scale, index 1 the eps term; always ready,
//   write only while no element is in flight
// throughput: one element per cycle while the skid register is empty; the pipeline is 73 stages, the square
//   root giving one result bit and the divider one quotient bit per stage
// stall: a skid register catches the result leaving the pipeline while
//   out_ch.ready is low; in_ch.ready drops while that register is full and the
//   whole pipeline holds, so nothing is lost or repeated
// reset: clears the valid bits (pipeline and skid register) and both config registers
//   (step scale and eps term read as +0.0)
module adam_optimizer_update_unit (
  input  logic        clk,
  input  logic        rst_n,
  adam_in_if.sink     in_ch,
  adam_out_if.source  out_ch,
  adam_cfg_if.sink    cfg_ch
);
  import adam_pkg::*;

  logic [31:0] step_scale_r;
  logic [31:0] eps_term_r;
  logic        skid_v_r;
  res_t        skid_d_r;
  logic        en;
  logic        dp_v;
  res_t        dp_res;
  res_t        res;
  in_t         din;

  // config registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_scale_r <= 32'd0;
      eps_term_r   <= 32'd0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_STEP_SCALE: step_scale_r <= cfg_ch.data;
        REG_EPS_TERM:   eps_term_r   <= cfg_ch.data;
      endcase
    end
  end

  // pipeline moves whenever the skid register is free
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  assign din.gradient      = in_ch.gradient;
  assign din.first_moment  = in_ch.first_moment;
  assign din.second_moment = in_ch.second_moment;
  assign din.weight        = in_ch.weight;
  assign din.last_element  = in_ch.last_element;

  adam_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .din       (din),
    .scale     (step_scale_r),
    .eps       (eps_term_r),
    .out_valid (dp_v),
    .dout      (dp_res)
  );

  // skid register: holds a result that leaves the pipeline during a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ch.ready) skid_v_r <= 1'b0;
    end else if (dp_v && !out_ch.ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) skid_d_r <= dp_res;
  end

  assign res                      = skid_v_r ? skid_d_r : dp_res;
  assign out_ch.valid             = skid_v_r | dp_v;
  assign out_ch.new_first_moment  = res.new_first_moment;
  assign out_ch.new_second_moment = res.new_second_moment;
  assign out_ch.new_weight        = res.new_weight;
  assign out_ch.last_out          = res.last_out;

endmodule

@@ sv/adam_chk.sv @@
module adam_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_nm,
  input logic [31:0] out_nv,
  input logic [31:0] out_nw,
  input logic        out_last
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_nm) && $stable(out_nv)
      && $stable(out_nw) && $stable(out_last))
    else $error("stalled result changed");

  // input side blocks only after an output stall
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input blocked without output stall");

  // a taken or absent result frees the input side
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_ready) |-> in_ready)
    else $error("input blocked after output was ready");

endmodule

bind adam_optimizer_update_unit adam_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_nm    (out_ch.new_first_moment),
  .out_nv    (out_ch.new_second_moment),
  .out_nw    (out_ch.new_weight),
  .out_last  (out_ch.last_out)
);
